// ===== rtl/spmv_pkg.sv =====
`default_nettype none

package spmv_pkg;

  localparam int unsigned ColumnW    = 10;
  localparam int unsigned ColumnSpan = 1 << ColumnW;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned ProdW      = 2 * ValueW;
  localparam int unsigned RowW       = 16;
  localparam int unsigned SumW       = 48;
  localparam int unsigned QueueDepth = 4;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef enum logic [1:0] {
    ActLoad    = 2'd0,
    ActNonzero = 2'd1,
    ActEndRow  = 2'd2,
    ActRestart = 2'd3
  } action_e;

  // work handed from the front end to the back end
  typedef struct packed {
    action_e                  action;
    logic signed [ValueW-1:0] coef;
    logic signed [ValueW-1:0] elem;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/spmv_in_if.sv =====
`default_nettype none

interface spmv_in_if import spmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_e                  action;
  logic [ColumnW-1:0]       column;
  logic signed [ValueW-1:0] entry_value;

  modport source (output valid, output action, output column, output entry_value,
                  input ready);
  modport sink (input valid, input action, input column, input entry_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/spmv_out_if.sv =====
`default_nettype none

interface spmv_out_if import spmv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RowW-1:0]        row_number;
  logic signed [SumW-1:0] row_sum;

  modport source (output valid, output row_number, output row_sum, input ready);
  modport sink (input valid, input row_number, input row_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/spmv_front.sv =====
`default_nettype none

module spmv_front import spmv_pkg::*; #(
  parameter int unsigned VECTOR_LENGTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spmv_in_if.sink   in_i,
  output logic      push_valid_o,
  input  wire logic push_ready_i,
  output op_t       push_op_o
);

  localparam int unsigned StoreDepth =
      (VECTOR_LENGTH < ColumnSpan) ? VECTOR_LENGTH : ColumnSpan;
  localparam int unsigned AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic [ValueW-1:0] store_q [StoreDepth];

  logic                     valid_q;
  action_e                  act_q;
  logic signed [ValueW-1:0] coef_q;
  logic signed [ValueW-1:0] elem_q;

  logic             accept;
  logic             col_ok;
  logic             drain;
  logic [AddrW-1:0] addr;

  assign addr   = in_i.column[AddrW-1:0];
  assign col_ok = 32'(in_i.column) < VECTOR_LENGTH;
  assign accept = in_i.valid && in_i.ready;
  // loads finish here, everything else moves on to the queue
  assign drain      = (act_q == ActLoad) || push_ready_i;
  assign in_i.ready = !valid_q || drain;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_i.action == ActLoad && col_ok) begin
        store_q[addr] <= in_i.entry_value;
      end
      elem_q <= col_ok ? $signed(store_q[addr]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_i.action;
      coef_q <= col_ok ? in_i.entry_value : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  assign push_valid_o = valid_q && (act_q != ActLoad);
  assign push_op_o    = '{action: act_q, coef: coef_q, elem: elem_q};

endmodule

`default_nettype wire

// ===== rtl/spmv_queue.sv =====
`default_nettype none

module spmv_queue import spmv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire op_t  push_op_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output op_t       pop_op_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic push;
  logic pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spmv_back.sv =====
`default_nettype none

module spmv_back import spmv_pkg::*; #(
  parameter longint unsigned MAX_ROWS = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire op_t   pop_op_i,
  spmv_out_if.source out_o
);

  logic                    m_valid_q;
  action_e                 m_act_q;
  logic signed [ProdW-1:0] m_prod_q;

  logic signed [SumW-1:0] acc_q;
  logic signed [SumW-1:0] acc_d;
  logic [RowW-1:0]        row_q;
  logic [RowW-1:0]        row_d;

  logic                   out_valid_q;
  logic [RowW-1:0]        out_row_q;
  logic signed [SumW-1:0] out_sum_q;

  logic                 go;
  logic                 load_m;
  logic signed [SumW:0] sum;
  logic [RowW:0]        row_inc;

  // an end of row waits only for a free output register
  assign go = m_valid_q &&
              !(m_act_q == ActEndRow && out_valid_q && !out_o.ready);
  assign load_m      = !m_valid_q || go;
  assign pop_ready_o = load_m;

  assign sum     = (SumW+1)'(acc_q) + (SumW+1)'(m_prod_q);
  assign row_inc = {1'b0, row_q} + 1'b1;

  always_comb begin
    acc_d = acc_q;
    row_d = row_q;
    if (go) begin
      case (m_act_q)
        ActNonzero: begin
          if (sum[SumW] != sum[SumW-1]) begin
            acc_d = sum[SumW] ? SumMin : SumMax;
          end else begin
            acc_d = sum[SumW-1:0];
          end
        end
        ActEndRow: begin
          acc_d = '0;
          row_d = (64'(row_inc) >= MAX_ROWS) ? '0 : row_inc[RowW-1:0];
        end
        ActRestart: begin
          acc_d = '0;
          row_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_m && pop_valid_i) begin
      m_act_q  <= pop_op_i.action;
      m_prod_q <= pop_op_i.coef * pop_op_i.elem;
    end
    if (go && m_act_q == ActEndRow) begin
      out_row_q <= row_q;
      out_sum_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      row_q       <= '0;
    end else begin
      if (load_m) begin
        m_valid_q <= pop_valid_i;
      end
      if (go && m_act_q == ActEndRow) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      acc_q <= acc_d;
      row_q <= row_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_number = out_row_q;
  assign out_o.row_sum    = out_sum_q;

endmodule

`default_nettype wire

// ===== rtl/csr_sparse_matrix_vector_multiply.sv =====
// Sparse matrix times dense vector, matrix streamed row by row in CSR order.
// Load words fill the vector store (one 16-bit entry per column, kept across
// restarts; only columns below VECTOR_LENGTH are stored). Nonzero words read
// x[column], multiply by the Q7.8 value and add into a Q31.16 accumulator that
// saturates at 48 bits; an end-of-row word returns the row number and sum and
// clears the accumulator; restart zeroes row counter and accumulator. When
// nothing stalls, the block accepts one word per clock, limited by the
// single-port vector store read and the one 16x16 multiplier. A row result
// moves through the store read register at the accepting edge, then the
// four-word queue, the multiply register and the output register. A held-off
// result backs up through the queue to the input. Read a column only after
// it has been loaded.
`default_nettype none

module csr_sparse_matrix_vector_multiply import spmv_pkg::*; #(
  parameter int unsigned     VECTOR_LENGTH = 1024,
  parameter longint unsigned MAX_ROWS      = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spmv_in_if.sink    in_i,
  spmv_out_if.source out_o
);

  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  spmv_front #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_op_o   (push_op)
  );

  spmv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_op_i   (push_op),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_op_o    (pop_op)
  );

  spmv_back #(
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_op_i   (pop_op),
    .out_o      (out_o)
  );

  a_load_stays_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action == ActLoad) |=> !push_valid)
    else $error("load word forwarded to back end");

  a_work_forwarded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action != ActLoad) |=> push_valid)
    else $error("accepted word not offered to queue");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_op)))
    else $error("queue head changed while stalled");

endmodule

`default_nettype wire
